// ----- rtl/ptd_pkg.sv -----
// Shared types and constants of the periodic task dispatcher.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ptd_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int MAX_OUT = 16;
    localparam int DIV_W = 64;
    localparam logic [31:0] LCM_SAT = 32'hFFFF_FFFF;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP = 3'd2;
    localparam logic [2:0] KIND_TICK = 3'd3;
    localparam logic [2:0] KIND_SETACT = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DISP = 2'd1;
    localparam logic [1:0] ST_REJ = 2'd2;

    localparam logic [1:0] SLOT_ZERO = 2'd0;
    localparam logic [1:0] SLOT_TOTAL = 2'd1;
    localparam logic [1:0] SLOT_REQ = 2'd2;
    localparam logic [1:0] SLOT_IDX = 2'd3;

    typedef struct packed {
        logic       latch_in;
        logic       slot_load;
        logic [1:0] slot_sel;
        logic       add_write;
        logic       act_write;
        logic       due_fill;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_issue;
        logic       run_set;
        logic       run_clr;
        logic       time_add;
        logic       lcm_load_p;
        logic       gcd_init;
        logic       div_gcd;
        logic       div_lcm;
        logic       div_scan;
        logic       gcd_step;
        logic       mul_go;
        logic       lcm_mul_load;
        logic       due_adv;
        logic       emit;
        logic [1:0] emit_status;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       add_ok;
        logic       slot_ok;
        logic       running;
        logic       lcm_zero;
        logic       lcm_sat;
        logic       gb_zero;
        logic       div_done;
        logic       hit;
        logic       idx_end;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/ptd_div.sv -----
// Restoring divider, one quotient bit per cycle, for GCD, LCM and catch-up.
// Depends on ptd_pkg.
`default_nettype none
module ptd_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ptd_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [31:0]               i_divisor,
    output logic                           o_done,
    output logic [ptd_pkg::DIV_W-1:0]      o_quo,
    output logic [31:0]                    o_rem
);
    localparam int CNT_W = $clog2(ptd_pkg::DIV_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [ptd_pkg::DIV_W-1:0] r_quo;
    logic [31:0]               r_rem;
    logic [31:0]               r_div;
    logic [32:0]               w_trial;
    logic [32:0]               w_diff;
    logic                      w_q;

    assign w_trial = {r_rem, r_quo[ptd_pkg::DIV_W-1]};
    assign w_diff = w_trial - {1'b0, r_div};
    assign w_q = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_quo <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_q ? w_diff[31:0] : w_trial[31:0];
                r_quo <= {r_quo[ptd_pkg::DIV_W-2:0], w_q};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ptd_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
endmodule
`default_nettype wire

// ----- rtl/ptd_dp.sv -----
// Datapath: task table memories, time, hyperperiod, GCD registers and result register.
// Depends on ptd_pkg and ptd_div.
`default_nettype none
module ptd_dp #(
    parameter int TASK_SLOTS = ptd_pkg::TASK_SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [2:0]     i_kind,
    input  wire logic [15:0]    i_period,
    input  wire logic [3:0]     i_slot,
    input  wire logic           i_flag,
    input  wire logic [9:0]     i_elapsed,
    input  wire ptd_pkg::t_cmd  i_cmd,
    output ptd_pkg::t_sts       o_sts,
    input  wire logic           i_ready,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [3:0]          o_slot,
    output logic [31:0]         o_hyper,
    output logic [4:0]          o_held,
    output logic                o_last
);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    logic [2:0]  r_kind;
    logic [15:0] r_period;
    logic [3:0]  r_slot;
    logic        r_flag;
    logic [9:0]  r_elapsed;
    logic [63:0] r_time;
    logic        r_running;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_idx;
    logic [31:0] r_lcm;
    logic [3:0]  r_res_slot;
    logic [31:0] r_ga;
    logic [31:0] r_gb;
    logic [47:0] r_prod;
    logic [15:0] m_period [TASK_SLOTS];
    logic        m_active [TASK_SLOTS];
    logic [63:0] m_due [TASK_SLOTS];
    logic [15:0] r_rd_period;
    logic        r_rd_active;
    logic [63:0] r_rd_due;
    logic        r_ovalid;
    logic [1:0]  r_ostatus;
    logic [3:0]  r_oslot;
    logic [31:0] r_ohyper;
    logic [4:0]  r_oheld;
    logic        r_olast;

    logic        w_div_start;
    logic [63:0] w_dividend;
    logic [31:0] w_divisor;
    logic        w_div_done;
    logic [63:0] w_quo;
    logic [31:0] w_rem;
    logic [3:0]  w_slot_next;

    always_comb begin
        w_dividend = {32'd0, r_ga};
        w_divisor = r_gb;
        if (i_cmd.div_lcm) begin
            w_dividend = {32'd0, r_lcm};
            w_divisor = r_ga;
        end else if (i_cmd.div_scan) begin
            w_dividend = r_time - r_rd_due;
            w_divisor = {16'd0, r_rd_period};
        end
    end
    assign w_div_start = i_cmd.div_gcd | i_cmd.div_lcm | i_cmd.div_scan;

    ptd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    always_comb begin
        case (i_cmd.slot_sel)
            ptd_pkg::SLOT_TOTAL: w_slot_next = 4'(r_total);
            ptd_pkg::SLOT_REQ:   w_slot_next = r_slot;
            ptd_pkg::SLOT_IDX:   w_slot_next = 4'(r_idx);
            default:             w_slot_next = 4'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_running <= 1'b0;
            r_total <= '0;
            r_lcm <= '0;
            r_idx <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.time_add) begin
                r_time <= r_time + 64'(r_elapsed);
            end
            if (i_cmd.run_set) begin
                r_running <= 1'b1;
            end else if (i_cmd.run_clr) begin
                r_running <= 1'b0;
            end
            if (i_cmd.add_write) begin
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.lcm_load_p) begin
                r_lcm <= {16'd0, r_period};
            end else if (i_cmd.lcm_mul_load) begin
                r_lcm <= (|r_prod[47:32]) ? ptd_pkg::LCM_SAT : r_prod[31:0];
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_kind <= i_kind;
            r_period <= i_period;
            r_slot <= i_slot;
            r_flag <= i_flag;
            r_elapsed <= i_elapsed;
        end
        if (i_cmd.slot_load) begin
            r_res_slot <= w_slot_next;
        end
        if (i_cmd.gcd_init) begin
            r_ga <= r_lcm;
            r_gb <= {16'd0, r_period};
        end else if (i_cmd.gcd_step) begin
            r_ga <= r_gb;
            r_gb <= w_rem;
        end
        if (i_cmd.mul_go) begin
            r_prod <= w_quo[31:0] * r_period;
        end
        if (i_cmd.emit) begin
            r_ostatus <= i_cmd.emit_status;
            r_oslot <= r_res_slot;
            r_ohyper <= r_lcm;
            r_oheld <= 5'(r_total);
            r_olast <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) begin
            m_period[r_total[IW-1:0]] <= r_period;
        end
        if (i_cmd.add_write) begin
            m_active[r_total[IW-1:0]] <= r_flag;
        end else if (i_cmd.act_write) begin
            m_active[IW'(r_slot)] <= r_flag;
        end
        if (i_cmd.add_write) begin
            m_due[r_total[IW-1:0]] <= r_time;
        end else if (i_cmd.due_fill) begin
            m_due[r_idx[IW-1:0]] <= r_time;
        end else if (i_cmd.due_adv) begin
            m_due[r_idx[IW-1:0]] <= r_time - 64'(w_rem) + 64'(r_rd_period);
        end
        if (i_cmd.rd_issue) begin
            r_rd_period <= m_period[r_idx[IW-1:0]];
            r_rd_active <= m_active[r_idx[IW-1:0]];
            r_rd_due <= m_due[r_idx[IW-1:0]];
        end
    end

    assign o_sts.kind = r_kind;
    assign o_sts.add_ok = (32'(r_total) < TASK_SLOTS) && (r_period != 16'd0);
    assign o_sts.slot_ok = 32'(r_slot) < 32'(r_total);
    assign o_sts.running = r_running;
    assign o_sts.lcm_zero = r_lcm == 32'd0;
    assign o_sts.lcm_sat = r_lcm == ptd_pkg::LCM_SAT;
    assign o_sts.gb_zero = r_gb == 32'd0;
    assign o_sts.div_done = w_div_done;
    assign o_sts.hit = r_rd_active && (r_time >= r_rd_due) && (r_rd_period != 16'd0);
    assign o_sts.idx_end = r_idx >= r_total;
    assign o_sts.out_free = !r_ovalid || i_ready;

    assign o_valid = r_ovalid;
    assign o_status = r_ostatus;
    assign o_slot = r_oslot;
    assign o_hyper = r_ohyper;
    assign o_held = r_oheld;
    assign o_last = r_olast;
endmodule
`default_nettype wire

// ----- rtl/ptd_ctrl.sv -----
// Controller state machine: decodes items, runs GCD/LCM, start sweep and tick scan.
// Depends on ptd_pkg; drives ptd_dp through command and status structs.
`default_nettype none
module ptd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ptd_pkg::t_sts i_sts,
    output ptd_pkg::t_cmd      o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_GCD_CHK, S_GCD_WAIT, S_LCM_WAIT, S_MUL, S_FILL,
        S_SCAN_RD, S_SCAN_EVAL, S_SCAN_DIV, S_SCAN_PUT, S_FINISH, S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_nout, n_nout;
    logic [1:0] r_emit_status, n_emit_status;

    always_comb begin
        n_state = r_state;
        n_nout = r_nout;
        n_emit_status = r_emit_status;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.slot_load = 1'b1;
                o_cmd.slot_sel = ptd_pkg::SLOT_ZERO;
                n_state = S_EMIT;
                n_emit_status = ptd_pkg::ST_DONE;
                case (i_sts.kind)
                    ptd_pkg::KIND_ADD: begin
                        if (i_sts.add_ok) begin
                            o_cmd.add_write = 1'b1;
                            o_cmd.slot_sel = ptd_pkg::SLOT_TOTAL;
                            if (i_sts.lcm_zero) begin
                                o_cmd.lcm_load_p = 1'b1;
                            end else if (!i_sts.lcm_sat) begin
                                o_cmd.gcd_init = 1'b1;
                                n_state = S_GCD_CHK;
                            end
                        end else begin
                            n_emit_status = ptd_pkg::ST_REJ;
                        end
                    end
                    ptd_pkg::KIND_START: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = S_FILL;
                    end
                    ptd_pkg::KIND_STOP: begin
                        o_cmd.run_clr = 1'b1;
                    end
                    ptd_pkg::KIND_TICK: begin
                        o_cmd.time_add = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_nout = 5'd0;
                        if (i_sts.running) begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    ptd_pkg::KIND_SETACT: begin
                        if (i_sts.slot_ok) begin
                            o_cmd.act_write = 1'b1;
                            o_cmd.slot_sel = ptd_pkg::SLOT_REQ;
                        end else begin
                            n_emit_status = ptd_pkg::ST_REJ;
                        end
                    end
                    default: begin
                        n_emit_status = ptd_pkg::ST_REJ;
                    end
                endcase
            end
            S_GCD_CHK: begin
                if (i_sts.gb_zero) begin
                    o_cmd.div_lcm = 1'b1;
                    n_state = S_LCM_WAIT;
                end else begin
                    o_cmd.div_gcd = 1'b1;
                    n_state = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.gcd_step = 1'b1;
                    n_state = S_GCD_CHK;
                end
            end
            S_LCM_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.mul_go = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.lcm_mul_load = 1'b1;
                n_emit_status = ptd_pkg::ST_DONE;
                n_state = S_EMIT;
            end
            S_FILL: begin
                if (i_sts.idx_end) begin
                    o_cmd.run_set = 1'b1;
                    n_emit_status = ptd_pkg::ST_DONE;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.due_fill = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.idx_end || r_nout == 5'(ptd_pkg::MAX_OUT)) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_SCAN_EVAL;
                end
            end
            S_SCAN_EVAL: begin
                if (i_sts.hit) begin
                    o_cmd.div_scan = 1'b1;
                    n_state = S_SCAN_DIV;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.due_adv = 1'b1;
                    n_state = S_SCAN_PUT;
                end
            end
            S_SCAN_PUT: begin
                if (r_nout == 5'd0 || i_sts.out_free) begin
                    o_cmd.emit = r_nout != 5'd0;
                    o_cmd.emit_status = ptd_pkg::ST_DISP;
                    o_cmd.slot_load = 1'b1;
                    o_cmd.slot_sel = ptd_pkg::SLOT_IDX;
                    o_cmd.idx_inc = 1'b1;
                    n_nout = r_nout + 5'd1;
                    n_state = S_SCAN_RD;
                end
            end
            S_FINISH: begin
                n_emit_status = (r_nout == 5'd0) ? ptd_pkg::ST_DONE : ptd_pkg::ST_DISP;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = r_emit_status;
                    o_cmd.emit_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nout <= 5'd0;
            r_emit_status <= ptd_pkg::ST_DONE;
        end else begin
            r_state <= n_state;
            r_nout <= n_nout;
            r_emit_status <= n_emit_status;
        end
    end

    assign o_in_ready = r_state == S_IDLE;
endmodule
`default_nettype wire

// ----- rtl/periodic_task_dispatcher_core.sv -----
// Top level of the periodic task dispatcher: controller, datapath and port packing.
// Depends on ptd_pkg, ptd_ctrl and ptd_dp.
//
//  Channel  | Direction | Fields
//  s_axis   | in        | tuser: kind; tdata: task_period, task_slot, active_flag, elapsed_ms
//  m_axis   | out       | tuser: status; tdata: dispatched_slot, hyperperiod, tasks_held;
//           |           | tlast: last
//
// One item is handled at a time. Stop, set active and rejected items go straight to the result;
// start writes the due time of every held task; an add onto a nonzero, unsaturated hyperperiod
// runs one bit-serial division per GCD step, then a final division and a multiply. A tick visits
// each task in turn and runs one division per dispatched task for the catch-up remainder.
// Reset is synchronous and active low and clears time, running, task count and hyperperiod.
// The next item is taken while a result still waits; a stalled output holds the scan.
`default_nettype none
module periodic_task_dispatcher_core #(
    parameter int TASK_SLOTS = ptd_pkg::TASK_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // task_period[15:0], task_slot[19:16], active_flag[20], elapsed_ms[30:21], zero[31]
    input  wire logic [31:0] i_s_axis_tdata,
    // kind[2:0]
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // dispatched_slot[3:0], hyperperiod[35:4], tasks_held[40:36], zero[47:41]
    output logic [47:0]      o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);
    ptd_pkg::t_cmd w_cmd;
    ptd_pkg::t_sts w_sts;
    logic [3:0]    w_oslot;
    logic [31:0]   w_ohyper;
    logic [4:0]    w_oheld;

    ptd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ptd_dp #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_kind    (i_s_axis_tuser),
        .i_period  (i_s_axis_tdata[15:0]),
        .i_slot    (i_s_axis_tdata[19:16]),
        .i_flag    (i_s_axis_tdata[20]),
        .i_elapsed (i_s_axis_tdata[30:21]),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_ready   (i_m_axis_tready),
        .o_valid   (o_m_axis_tvalid),
        .o_status  (o_m_axis_tuser),
        .o_slot    (w_oslot),
        .o_hyper   (w_ohyper),
        .o_held    (w_oheld),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'd0, w_oheld, w_ohyper, w_oslot};

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while an item is in work");

    a_rej_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ptd_pkg::ST_REJ |-> o_m_axis_tlast)
        else $error("rejected result not marked last");

    a_disp_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ptd_pkg::ST_DISP && TASK_SLOTS <= 16
        |-> o_m_axis_tdata[3:0] < o_m_axis_tdata[40:36])
        else $error("dispatched slot beyond task count");

    a_rej_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ptd_pkg::ST_REJ |-> o_m_axis_tdata[3:0] == 4'd0)
        else $error("rejected result names a slot");
endmodule
`default_nettype wire

// ----- tb/sv/ptd_checker.sv -----
`timescale 1ns / 1ps
// Checker for the periodic task dispatcher: watches both stream channels, predicts
// every result from its own copy of the task table and compares. Depends on ptd_pkg.
module ptd_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,
    input  wire logic [2:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [47:0] i_m_tdata,
    input  wire logic [1:0]  i_m_tuser,
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending
);
    typedef struct {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] hyper;
        logic [4:0]  held;
        logic        last;
    } t_dispatch;

    t_dispatch   expected_results[$];
    logic [63:0] clock_ms;
    logic        sched_running;
    logic [4:0]  task_count;
    logic [31:0] hyper_lcm;
    logic [15:0] period_tab[16];
    logic        active_tab[16];
    logic [63:0] due_tab[16];
    int          fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending = expected_results.size();

    function automatic logic [31:0] lcm_next(input logic [31:0] old, input logic [15:0] p);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [63:0] v;
        if (old == 32'd0) return {16'd0, p};
        if (old == ptd_pkg::LCM_SAT) return ptd_pkg::LCM_SAT;
        a = old;
        b = {16'd0, p};
        while (b != 32'd0) begin
            r = a % b;
            a = b;
            b = r;
        end
        v = {32'd0, old / a} * {48'd0, p};
        return (v > {32'd0, ptd_pkg::LCM_SAT}) ? ptd_pkg::LCM_SAT : v[31:0];
    endfunction

    task automatic push_result(input logic [1:0] st, input logic [3:0] sl, input logic lst);
        t_dispatch r;
        r.status = st;
        r.slot = sl;
        r.hyper = hyper_lcm;
        r.held = task_count;
        r.last = lst;
        expected_results.push_back(r);
    endtask

    task automatic predict_dispatch(input logic [2:0] k, input logic [31:0] d);
        logic [15:0] per;
        logic [3:0]  sl;
        logic        fl;
        logic [63:0] p;
        int          n;
        int          idx;
        per = d[15:0];
        sl = d[19:16];
        fl = d[20];
        case (k)
            ptd_pkg::KIND_ADD: begin
                if (task_count >= 5'd16 || per == 16'd0) begin
                    push_result(ptd_pkg::ST_REJ, 4'd0, 1'b1);
                end else begin
                    idx = task_count;
                    period_tab[idx] = per;
                    active_tab[idx] = fl;
                    due_tab[idx] = clock_ms;
                    task_count = task_count + 5'd1;
                    hyper_lcm = lcm_next(hyper_lcm, per);
                    push_result(ptd_pkg::ST_DONE, idx[3:0], 1'b1);
                end
            end
            ptd_pkg::KIND_START: begin
                for (idx = 0; idx < task_count; idx++) due_tab[idx] = clock_ms;
                sched_running = 1'b1;
                push_result(ptd_pkg::ST_DONE, 4'd0, 1'b1);
            end
            ptd_pkg::KIND_STOP: begin
                sched_running = 1'b0;
                push_result(ptd_pkg::ST_DONE, 4'd0, 1'b1);
            end
            ptd_pkg::KIND_TICK: begin
                clock_ms = clock_ms + {54'd0, d[30:21]};
                n = 0;
                if (sched_running) begin
                    for (idx = 0; idx < task_count; idx++) begin
                        p = {48'd0, period_tab[idx]};
                        if (active_tab[idx] && clock_ms >= due_tab[idx] && p != 64'd0) begin
                            due_tab[idx] = due_tab[idx]
                                + ((clock_ms - due_tab[idx]) / p + 64'd1) * p;
                            push_result(ptd_pkg::ST_DISP, idx[3:0], 1'b0);
                            n++;
                        end
                    end
                end
                if (n == 0) push_result(ptd_pkg::ST_DONE, 4'd0, 1'b1);
                else expected_results[$].last = 1'b1;
            end
            ptd_pkg::KIND_SETACT: begin
                if ({1'b0, sl} >= task_count) begin
                    push_result(ptd_pkg::ST_REJ, 4'd0, 1'b1);
                end else begin
                    active_tab[sl] = fl;
                    push_result(ptd_pkg::ST_DONE, sl, 1'b1);
                end
            end
            default: push_result(ptd_pkg::ST_REJ, 4'd0, 1'b1);
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_dispatch w;
        if (!i_rst_n) begin
            clock_ms = 64'd0;
            sched_running = 1'b0;
            task_count = 5'd0;
            hyper_lcm = 32'd0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) predict_dispatch(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", i_m_tdata, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (i_m_tuser != w.status) report_mismatch("status", i_m_tuser, w.status);
                    if (i_m_tdata[3:0] != w.slot) report_mismatch("slot", i_m_tdata[3:0], w.slot);
                    if (i_m_tdata[35:4] != w.hyper)
                        report_mismatch("hyperperiod", i_m_tdata[35:4], w.hyper);
                    if (i_m_tdata[40:36] != w.held)
                        report_mismatch("tasks_held", i_m_tdata[40:36], w.held);
                    if (i_m_tlast != w.last) report_mismatch("last", i_m_tlast, w.last);
                end
            end
        end
    end
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Top of the periodic task dispatcher testbench: clock, reset, stimulus and verdict.
// Depends on ptd_pkg, ptd_checker and periodic_task_dispatcher_core.
module tb;
    localparam int HOLD_AT = 120;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = 32'd0;
    logic [2:0]  s_tuser = 3'd0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          tx_idle = 9;
    int          rx_idle = 80;
    int          sent_count = 0;
    int          hold_cnt = 0;
    logic        hold_done = 1'b0;

    periodic_task_dispatcher_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser), .o_m_axis_tlast(m_tlast)
    );

    ptd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (!hold_done && sent_count == HOLD_AT) begin
            hold_done <= 1'b1;
            hold_cnt <= 400;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic send_item(input logic [2:0] k, input logic [15:0] per, input logic [3:0] sl,
                             input logic fl, input logic [9:0] el);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= {1'b0, el, fl, sl, per};
        do @(posedge i_clk); while (!s_tready);
        sent_count <= sent_count + 1;
    endtask

    task automatic send_random();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            send_item(ptd_pkg::KIND_TICK, 16'($urandom), 4'($urandom), 1'($urandom),
                      10'(($urandom_range(9) == 0) ? $urandom_range(1023)
                                                   : $urandom_range(40)));
        else if (r < 67)
            send_item(ptd_pkg::KIND_ADD,
                      16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 12)),
                      4'($urandom), 1'($urandom), 10'($urandom));
        else if (r < 80)
            send_item(ptd_pkg::KIND_SETACT, 16'($urandom), 4'($urandom), 1'($urandom),
                      10'($urandom));
        else if (r < 86)
            send_item(ptd_pkg::KIND_START, 16'($urandom), 4'($urandom), 1'($urandom),
                      10'($urandom));
        else if (r < 91)
            send_item(ptd_pkg::KIND_STOP, 16'($urandom), 4'($urandom), 1'($urandom),
                      10'($urandom));
        else if (r < 95)
            send_item(3'($urandom_range(5, 7)), 16'($urandom), 4'($urandom), 1'($urandom),
                      10'($urandom));
        else
            send_item(ptd_pkg::KIND_TICK, 16'($urandom), 4'($urandom), 1'($urandom),
                      10'd1023);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_item(ptd_pkg::KIND_TICK, 16'd0, 4'd0, 1'b0, 10'd5);
        send_item(ptd_pkg::KIND_SETACT, 16'd0, 4'd0, 1'b1, 10'd0);
        send_item(ptd_pkg::KIND_ADD, 16'd0, 4'd0, 1'b1, 10'd0);
        send_item(ptd_pkg::KIND_ADD, 16'd1, 4'd0, 1'b1, 10'd0);
        send_item(ptd_pkg::KIND_ADD, 16'd6, 4'd15, 1'b1, 10'd1023);
        send_item(ptd_pkg::KIND_ADD, 16'd4, 4'd0, 1'b0, 10'd0);
        send_item(ptd_pkg::KIND_START, 16'd0, 4'd0, 1'b0, 10'd0);
        send_item(ptd_pkg::KIND_TICK, 16'd0, 4'd0, 1'b0, 10'd0);
        send_item(ptd_pkg::KIND_TICK, 16'hFFFF, 4'd15, 1'b1, 10'd1023);
        send_item(ptd_pkg::KIND_SETACT, 16'd0, 4'd2, 1'b1, 10'd0);
        send_item(ptd_pkg::KIND_SETACT, 16'd0, 4'd0, 1'b0, 10'd0);
        send_item(ptd_pkg::KIND_SETACT, 16'd0, 4'd15, 1'b1, 10'd0);
        send_item(ptd_pkg::KIND_TICK, 16'd0, 4'd0, 1'b0, 10'd7);
        send_item(ptd_pkg::KIND_ADD, 16'd9, 4'd0, 1'b1, 10'd0);
        send_item(ptd_pkg::KIND_START, 16'd0, 4'd0, 1'b0, 10'd0);
        send_item(ptd_pkg::KIND_TICK, 16'd0, 4'd0, 1'b0, 10'd1);
        send_item(ptd_pkg::KIND_STOP, 16'd0, 4'd0, 1'b0, 10'd0);
        send_item(ptd_pkg::KIND_TICK, 16'd0, 4'd0, 1'b0, 10'd100);
        send_item(3'd5, 16'hFFFF, 4'd15, 1'b1, 10'h3FF);
        send_item(3'd6, 16'd0, 4'd0, 1'b0, 10'd0);
        send_item(3'd7, 16'd0, 4'd0, 1'b0, 10'd0);
        send_item(ptd_pkg::KIND_START, 16'd0, 4'd0, 1'b0, 10'd0);
        send_item(ptd_pkg::KIND_ADD, 16'hFFFF, 4'd0, 1'b1, 10'd0);
        send_item(ptd_pkg::KIND_TICK, 16'd0, 4'd0, 1'b0, 10'd3);
        repeat (42) send_random();
        tx_idle <= 80;
        rx_idle <= 9;
        repeat (42) send_random();
        tx_idle <= 0;
        rx_idle <= 0;
        repeat (42) send_random();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("periodic_task_dispatcher_core verification clean");
        end else begin
            $display("periodic_task_dispatcher_core verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("periodic_task_dispatcher_core verification failed");
        $finish;
    end
endmodule
